/* hdl/bptsc_pkg.sv */
package bptsc_pkg;

    localparam int MAX_SLOTS = 16;
    localparam int SLOT_W    = 4;
    localparam int ADDR_W    = 32;

    localparam logic [7:0]        ARM_BYTE        = 8'hCC;
    localparam logic [ADDR_W-1:0] REGION_BASE_RST = 32'h0040_0000;
    localparam logic [ADDR_W-1:0] REGION_TOP_RST  = 32'h0080_0000;
    localparam logic [ADDR_W-1:0] LOAD_ADDR_RST   = 32'h0040_0000;

    typedef enum logic [2:0] {
        K_START,
        K_SET,
        K_DELETE,
        K_STOP,
        K_BP_TRAP,
        K_STEP_TRAP,
        K_CONTINUE,
        K_STEP
    } t_kind;

    typedef enum logic [2:0] {
        STAT_OK,
        STAT_OUTSIDE,
        STAT_EXISTS,
        STAT_FULL,
        STAT_NOT_FOUND,
        STAT_FAULT,
        STAT_IGNORED
    } t_status;

    typedef enum logic [1:0] {
        TF_LEAVE,
        TF_SET,
        TF_CLEAR
    } t_tf_action;

    typedef enum logic [1:0] {
        CFG_REGION_BASE,
        CFG_REGION_TOP,
        CFG_LOAD_ADDRESS
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_EXEC,
        ST_WALK
    } t_state;

    typedef struct packed {
        t_kind             kind;
        logic              code_read;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        mem_byte;
        logic              from_user;
    } t_item;

    typedef struct packed {
        t_status           status;
        logic              patch_valid;
        logic [ADDR_W-1:0] patch_addr;
        logic [7:0]        patch_byte;
        logic [ADDR_W-1:0] resume_addr;
        logic              stop_here;
        t_tf_action        trap_flag_action;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        code_byte_out;
        logic              last;
    } t_result;

    typedef struct packed {
        logic latch;
        logic look;
        logic exec;
        logic walk;
    } t_dp_cmd;

    typedef struct packed {
        logic walk_go;
        logic walk_last;
    } t_dp_stat;

endpackage

/* hdl/breakpoint_table_step_control.sv */
// Channel   Direction  Signals                                    Beat
// command   in         start, busy, i_item                        start && !busy
// result    out        o_strobe, o_result                         o_strobe (one cycle)
// config    in         i_cfg_valid, o_cfg_ready, i_cfg_index,     i_cfg_valid && o_cfg_ready
//                      i_cfg_data
//
// A command passes ST_LOOK, which matches the address against all entries in
// parallel, and ST_EXEC, which updates the table and loads the result register;
// the result shows in the cycle after ST_EXEC. Stop walks the table with a
// counter, one entry per cycle.
// Reset is synchronous, active low; the table comes up empty, no clearing pass.
// Results cannot be held off; busy only covers lookup and the stop walk.
module breakpoint_table_step_control import bptsc_pkg::*; #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_item             i_item,
    output logic              o_strobe,
    output t_result           o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [ADDR_W-1:0] i_cfg_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    bptsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (dp_cmd),
        .i_stat  (dp_stat)
    );

    bptsc_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (dp_cmd),
        .i_item      (i_item),
        .o_stat      (dp_stat),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    // a code read always answers with one final beat
    a_code_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.code_read) |-> ##3 (o_strobe && o_result.last))
        else $error("code read result missing");

    // only the stop walk gives non-final beats, and it keeps the block busy
    a_walk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |-> (busy && o_result.patch_valid))
        else $error("non-final beat outside stop walk");

    // a code read beat never carries a patch
    a_code_no_patch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.code_byte_out != 8'd0)) |-> !o_result.patch_valid)
        else $error("code read beat with patch");

endmodule

/* hdl/bptsc_ctrl.sv */
module bptsc_ctrl import bptsc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_LOOK;
                end
            end
            ST_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = ST_EXEC;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.walk_go) begin
                    n_state = ST_WALK;
                end else begin
                    // next command may be taken while this one commits
                    busy = 1'b0;
                    if (start) begin
                        o_cmd.latch = 1'b1;
                        n_state     = ST_LOOK;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/bptsc_dp.sv */
module bptsc_dp import bptsc_pkg::*; #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [ADDR_W-1:0] i_cfg_data,
    input  t_dp_cmd           i_cmd,
    input  t_item             i_item,
    output t_dp_stat          o_stat,
    output logic              o_strobe,
    output t_result           o_result
);

    localparam int N  = (TABLE_ENTRIES > MAX_SLOTS) ? MAX_SLOTS : TABLE_ENTRIES;
    localparam int IW = (N > 1) ? $clog2(N) : 1;

    typedef logic [IW-1:0] t_idx;

    // configuration
    logic [ADDR_W-1:0] r_region_base;
    logic [ADDR_W-1:0] r_region_top;
    logic [ADDR_W-1:0] r_load_address;

    // breakpoint table
    logic [ADDR_W-1:0] r_addr_mem [N];
    logic [7:0]        r_byte_mem [N];
    logic [N-1:0]      r_valid;
    logic [N-1:0]      n_valid;

    // step-over state
    logic r_debug, n_debug;
    logic r_parked_valid, n_parked_valid;
    t_idx r_parked_idx, n_parked_idx;
    logic r_rearm_valid, n_rearm_valid;
    t_idx r_rearm_idx, n_rearm_idx;
    logic r_step_wanted, n_step_wanted;

    // latched command and lookup results
    t_item r_item;
    logic  r_hit;
    t_idx  r_hit_idx;
    logic  r_free_hit;
    t_idx  r_free_idx;
    logic  r_in_region;
    t_idx  r_sel;
    t_idx  r_cnt, n_cnt;

    logic    r_strobe, n_strobe;
    t_result r_result, n_result;

    // lookup
    logic [ADDR_W-1:0] match_addr;
    logic [N-1:0]      match_vec;
    logic              look_hit;
    t_idx              look_hit_idx;
    logic              look_free_hit;
    t_idx              look_free_idx;
    logic              is_start;

    // table write port
    logic              tbl_we;
    t_idx              tbl_idx;
    logic [ADDR_W-1:0] tbl_addr;
    logic [7:0]        tbl_byte;

    // table read port
    t_idx              rd_idx;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_byte;

    logic more_above;
    logic user_ok;

    assign is_start = !r_item.code_read && (r_item.kind == K_START);

    always_comb begin
        if (r_item.code_read) begin
            match_addr = r_item.addr;
        end else if (r_item.kind == K_START) begin
            match_addr = r_load_address;
        end else if (r_item.kind == K_BP_TRAP) begin
            match_addr = r_item.addr - 32'd1;
        end else begin
            match_addr = r_item.addr;
        end
    end

    always_comb begin
        look_hit      = 1'b0;
        look_hit_idx  = '0;
        look_free_hit = 1'b0;
        look_free_idx = '0;
        for (int i = 0; i < N; i++) begin
            match_vec[i] = r_valid[i] && (r_addr_mem[i] == match_addr);
        end
        // lowest index wins
        for (int i = N - 1; i >= 0; i--) begin
            if (match_vec[i]) begin
                look_hit     = 1'b1;
                look_hit_idx = t_idx'(i);
            end
            if (!r_valid[i]) begin
                look_free_hit = 1'b1;
                look_free_idx = t_idx'(i);
            end
        end
    end

    assign rd_idx  = i_cmd.walk ? r_cnt : r_sel;
    assign rd_addr = r_addr_mem[rd_idx];
    assign rd_byte = r_byte_mem[rd_idx];

    always_comb begin
        more_above = 1'b0;
        for (int i = 0; i < N; i++) begin
            if (r_valid[i] && (t_idx'(i) > r_cnt)) begin
                more_above = 1'b1;
            end
        end
    end

    assign o_stat.walk_go   = !r_item.code_read && (r_item.kind == K_STOP) && (|r_valid);
    assign o_stat.walk_last = !more_above;

    assign user_ok = r_debug && r_item.from_user;

    always_comb begin
        n_valid        = r_valid;
        n_debug        = r_debug;
        n_parked_valid = r_parked_valid;
        n_parked_idx   = r_parked_idx;
        n_rearm_valid  = r_rearm_valid;
        n_rearm_idx    = r_rearm_idx;
        n_step_wanted  = r_step_wanted;
        n_cnt          = r_cnt;
        n_strobe       = 1'b0;
        n_result       = '0;
        tbl_we         = 1'b0;
        tbl_idx        = r_free_idx;
        tbl_addr       = r_item.addr;
        tbl_byte       = r_item.mem_byte;

        if (i_cmd.exec) begin
            n_strobe      = 1'b1;
            n_result.last = 1'b1;
            if (r_item.code_read) begin
                if (r_hit) begin
                    n_result.slot          = SLOT_W'(r_hit_idx);
                    n_result.code_byte_out = rd_byte;
                end else begin
                    n_result.code_byte_out = r_item.mem_byte;
                end
            end else begin
                unique case (r_item.kind)
                    K_START: begin
                        n_valid        = '0;
                        n_parked_valid = 1'b0;
                        n_parked_idx   = '0;
                        n_rearm_valid  = 1'b0;
                        n_rearm_idx    = '0;
                        n_step_wanted  = 1'b0;
                        n_debug        = 1'b1;
                        if (!r_in_region) begin
                            n_result.status = STAT_OUTSIDE;
                        end else begin
                            tbl_we               = 1'b1;
                            tbl_idx              = '0;
                            tbl_addr             = r_load_address;
                            n_valid[0]           = 1'b1;
                            n_result.patch_valid = 1'b1;
                            n_result.patch_addr  = r_load_address;
                            n_result.patch_byte  = ARM_BYTE;
                        end
                    end
                    K_SET: begin
                        if (!r_debug) begin
                            n_result.status = STAT_IGNORED;
                        end else if (!r_in_region) begin
                            n_result.status = STAT_OUTSIDE;
                        end else if (r_hit) begin
                            n_result.status = STAT_EXISTS;
                            n_result.slot   = SLOT_W'(r_hit_idx);
                        end else if (!r_free_hit) begin
                            n_result.status = STAT_FULL;
                        end else begin
                            tbl_we               = 1'b1;
                            n_valid[r_free_idx]  = 1'b1;
                            n_result.patch_valid = 1'b1;
                            n_result.patch_addr  = r_item.addr;
                            n_result.patch_byte  = ARM_BYTE;
                            n_result.slot        = SLOT_W'(r_free_idx);
                        end
                    end
                    K_DELETE: begin
                        if (!r_debug) begin
                            n_result.status = STAT_IGNORED;
                        end else if (!r_hit) begin
                            n_result.status = STAT_NOT_FOUND;
                        end else begin
                            n_result.patch_valid = 1'b1;
                            n_result.patch_addr  = rd_addr;
                            n_result.patch_byte  = rd_byte;
                            n_result.slot        = SLOT_W'(r_hit_idx);
                            n_valid[r_hit_idx]   = 1'b0;
                            if (r_parked_valid && (r_parked_idx == r_hit_idx)) begin
                                n_parked_valid = 1'b0;
                            end
                            if (r_rearm_valid && (r_rearm_idx == r_hit_idx)) begin
                                n_rearm_valid = 1'b0;
                            end
                        end
                    end
                    K_STOP: begin
                        n_debug        = 1'b0;
                        n_parked_valid = 1'b0;
                        n_rearm_valid  = 1'b0;
                        n_step_wanted  = 1'b0;
                        if (|r_valid) begin
                            // disarm beats come from the walk
                            n_strobe = 1'b0;
                            n_cnt    = '0;
                        end
                    end
                    K_BP_TRAP: begin
                        if (!user_ok) begin
                            n_result.status = STAT_FAULT;
                        end else begin
                            n_result.stop_here = 1'b1;
                            if (r_hit) begin
                                n_result.resume_addr = match_addr;
                                n_result.patch_valid = 1'b1;
                                n_result.patch_addr  = match_addr;
                                n_result.patch_byte  = rd_byte;
                                n_result.slot        = SLOT_W'(r_hit_idx);
                                n_parked_valid       = 1'b1;
                                n_parked_idx         = r_hit_idx;
                            end else begin
                                n_result.resume_addr = r_item.addr;
                                n_parked_valid       = 1'b0;
                            end
                        end
                    end
                    K_STEP_TRAP: begin
                        if (!user_ok) begin
                            n_result.status = STAT_IGNORED;
                        end else begin
                            n_result.resume_addr = r_item.addr;
                            if (r_rearm_valid) begin
                                if (r_valid[r_rearm_idx]) begin
                                    n_result.patch_valid = 1'b1;
                                    n_result.patch_addr  = rd_addr;
                                    n_result.patch_byte  = ARM_BYTE;
                                    n_result.slot        = SLOT_W'(r_rearm_idx);
                                end
                                n_rearm_valid = 1'b0;
                            end
                            if (r_step_wanted) begin
                                n_parked_valid     = 1'b0;
                                n_result.stop_here = 1'b1;
                            end else begin
                                n_result.trap_flag_action = TF_CLEAR;
                            end
                        end
                    end
                    K_CONTINUE: begin
                        if (!r_debug) begin
                            n_result.status = STAT_IGNORED;
                        end else begin
                            n_step_wanted = 1'b0;
                            if (r_parked_valid) begin
                                n_result.trap_flag_action = TF_SET;
                                n_rearm_valid             = 1'b1;
                                n_rearm_idx               = r_parked_idx;
                                n_result.slot             = SLOT_W'(r_parked_idx);
                            end else begin
                                n_result.trap_flag_action = TF_CLEAR;
                            end
                        end
                    end
                    K_STEP: begin
                        if (!r_debug) begin
                            n_result.status = STAT_IGNORED;
                        end else begin
                            n_result.trap_flag_action = TF_SET;
                            n_step_wanted             = 1'b1;
                            if (r_parked_valid) begin
                                n_rearm_valid = 1'b1;
                                n_rearm_idx   = r_parked_idx;
                                n_result.slot = SLOT_W'(r_parked_idx);
                            end
                        end
                    end
                    default: begin
                        n_result.status = STAT_IGNORED;
                    end
                endcase
            end
        end else if (i_cmd.walk) begin
            if (r_valid[r_cnt]) begin
                n_strobe             = 1'b1;
                n_valid[r_cnt]       = 1'b0;
                n_result.patch_valid = 1'b1;
                n_result.patch_addr  = rd_addr;
                n_result.patch_byte  = rd_byte;
                n_result.slot        = SLOT_W'(r_cnt);
                n_result.last        = !more_above;
            end
            n_cnt = r_cnt + t_idx'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_base  <= REGION_BASE_RST;
            r_region_top   <= REGION_TOP_RST;
            r_load_address <= LOAD_ADDR_RST;
            r_valid        <= '0;
            r_debug        <= 1'b0;
            r_parked_valid <= 1'b0;
            r_parked_idx   <= '0;
            r_rearm_valid  <= 1'b0;
            r_rearm_idx    <= '0;
            r_step_wanted  <= 1'b0;
            r_strobe       <= 1'b0;
        end else begin
            r_valid        <= n_valid;
            r_debug        <= n_debug;
            r_parked_valid <= n_parked_valid;
            r_parked_idx   <= n_parked_idx;
            r_rearm_valid  <= n_rearm_valid;
            r_rearm_idx    <= n_rearm_idx;
            r_step_wanted  <= n_step_wanted;
            r_strobe       <= n_strobe;
            if (i_cfg_valid) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    CFG_REGION_BASE:  r_region_base  <= i_cfg_data;
                    CFG_REGION_TOP:   r_region_top   <= i_cfg_data;
                    CFG_LOAD_ADDRESS: r_load_address <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
        if (i_cmd.look) begin
            r_hit       <= look_hit && !is_start;
            r_hit_idx   <= look_hit_idx;
            r_free_hit  <= look_free_hit || is_start;
            r_free_idx  <= is_start ? t_idx'(0) : look_free_idx;
            r_in_region <= (match_addr >= r_region_base) && (match_addr < r_region_top);
            r_sel       <= (!r_item.code_read && (r_item.kind == K_STEP_TRAP)) ?
                           r_rearm_idx : look_hit_idx;
        end
        if (tbl_we) begin
            r_addr_mem[tbl_idx] <= tbl_addr;
            r_byte_mem[tbl_idx] <= tbl_byte;
        end
        r_cnt    <= n_cnt;
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
